>>> rtl/msat_pkg.sv
// Package for the alarm slot table: widths, codes and the slot record type.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package msat_pkg;
   localparam int MaxAlarms   = 16;
   localparam int IdxW        = $clog2(MaxAlarms);
   localparam int CntW        = $clog2(MaxAlarms + 1);
   localparam int MinutesDay  = 24 * 60;
   localparam int MinutesHour = 60;

   typedef enum logic [2:0] {
      KIND_ADD     = 3'd0,
      KIND_REMOVE  = 3'd1,
      KIND_SET_EN  = 3'd2,
      KIND_DIS_ALL = 3'd3,
      KIND_ACK     = 3'd4,
      KIND_CLEAR   = 3'd5,
      KIND_TICK    = 3'd6,
      KIND_NONE    = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic       enabled;
      logic [5:0] sound;
   } slot_type;

   // Per-pass command from the controller to every cell.
   typedef struct packed {
      logic       shift;      // take the neighbor's slot (remove pass)
      logic       write_en;   // overwrite enable bit
      logic       en_value;
      logic       load;       // cell at load_index takes new slot
      logic [IdxW-1:0] load_index;
      logic [IdxW-1:0] rm_index;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;
endpackage
`default_nettype wire

>>> rtl/multi_slot_alarm_table_top.sv
// Top level of the alarm slot table: controller, scan unit and cell row.
// Depends on msat_pkg and msat_cell.
`default_nettype none
// The table keeps up to MaxAlarms alarm slots in a row of cells. Each word
// is handled in two passes of one slot per cycle. A compare pass covers the
// slots in use plus a closing step that also applies the change to the
// cell row. A second pass then collects the enabled summary over the updated
// table. The response sits in an output register and blocks the input until
// it is delivered. The next word is taken in the cycle after delivery.
// Remove, enable-all and load are applied to the whole cell row at once.
module multi_slot_alarm_table_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_kind,
   input  wire logic [4:0] req_time_hour,
   input  wire logic [5:0] req_time_minute,
   input  wire logic [5:0] req_time_second,
   input  wire logic [4:0] req_alarm_hour,
   input  wire logic [5:0] req_alarm_minute,
   input  wire logic [5:0] req_alarm_sound,
   input  wire logic       req_enable_flag,
   input  wire logic [3:0] req_entry_index,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_status,
   output logic            rsp_ringing,
   output logic [3:0]      rsp_ring_index,
   output logic [5:0]      rsp_ring_sound,
   output logic            rsp_triggered,
   output logic            rsp_next_valid,
   output logic [4:0]      rsp_next_hour,
   output logic [5:0]      rsp_next_minute,
   output logic [10:0]     rsp_minutes_until,
   output logic [4:0]      rsp_alarm_count,
   output logic            rsp_any_enabled
);
   import msat_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff;
   logic [4:0] th_ff, ah_ff;
   logic [5:0] tm_ff, ts_ff, am_ff, as_ff;
   logic en_ff;
   logic [3:0] idx_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic ring_ff, ring_in;
   logic [IdxW-1:0] rslot_ff, rslot_in;
   logic [5:0] rtrack_ff, rtrack_in;
   logic dup_ff, dup_in, trig_ff, trig_in, nv_ff, nv_in, any_ff, any_in;
   logic [4:0] nh_ff, nh_in;
   logic [5:0] nm_ff, nm_in;
   logic [10:0] nd_ff, nd_in, now_ff;
   logic [1:0] status_ff, status_in;

   slot_type     slots [MaxAlarms];
   slot_type     new_slot;
   cell_cmd_type cmd;
   logic accept;

   assign accept = req_valid && req_ready;
   assign new_slot = '{hour: ah_ff, minute: am_ff, enabled: en_ff, sound: as_ff};

   // Cell row: each cell at or above the removed index takes its upper neighbor's slot on remove.
   for (genvar g = 0; g < MaxAlarms; g++) begin : g_cell
      slot_type up;
      if (g == MaxAlarms - 1) begin : g_last
         assign up = slots[g];
      end else begin : g_mid
         assign up = slots[g+1];
      end
      msat_cell u_cell (
         .clock    (clock),
         .my_index (IdxW'(g)),
         .cmd      (cmd),
         .new_slot (new_slot),
         .up_slot  (up),
         .slot     (slots[g])
      );
   end

   // Scan unit: one slot per cycle, computes match, nearest and duplicate.
   slot_type   cur;
   logic [10:0] at, diff;
   logic [12:0] raw;
   logic scan_live;
   assign scan_live = (pos_ff < count_ff);
   assign cur  = slots[pos_ff[IdxW-1:0]];
   assign at   = 11'(cur.hour) * 11'(MinutesHour) + 11'(cur.minute);

   // For times within one day the distance before reduction stays below three
   // days, so two conditional subtractions bring it into one day.
   always_comb begin
      raw = 13'(at) + 13'(2 * MinutesDay) - 13'(now_ff);
      if (raw >= 13'(2 * MinutesDay)) raw = raw - 13'(2 * MinutesDay);
      if (raw >= 13'(MinutesDay)) raw = raw - 13'(MinutesDay);
      diff = raw[10:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_SCAN;
         S_SCAN: if (!scan_live) state_in = S_RESP;
         S_RESP: if (rsp_valid && rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      pos_in = pos_ff; dup_in = dup_ff; trig_in = trig_ff; nv_in = nv_ff;
      nh_in = nh_ff; nm_in = nm_ff; nd_in = nd_ff; any_in = any_ff;
      count_in = count_ff; ring_in = ring_ff; rslot_in = rslot_ff;
      rtrack_in = rtrack_ff; status_in = status_ff;
      cmd = '0;
      cmd.load_index = count_ff[IdxW-1:0];
      cmd.rm_index = idx_ff[IdxW-1:0];
      cmd.en_value = (kind_ff == KIND_SET_EN) ? en_ff : 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            pos_in = '0; dup_in = 1'b0; trig_in = 1'b0; nv_in = 1'b0;
            nh_in = '0; nm_in = '0; nd_in = '0; any_in = 1'b0;
         end
         S_SCAN: begin
            if (scan_live) begin
               pos_in = pos_ff + 1'b1;
               if (cur.hour == ah_ff && cur.minute == am_ff) dup_in = 1'b1;
               if (kind_ff == KIND_TICK && cur.enabled) begin
                  if (!trig_ff && cur.hour == th_ff && cur.minute == tm_ff
                      && ts_ff == 6'd0) begin
                     trig_in = 1'b1;
                     ring_in = 1'b1;
                     rslot_in = pos_ff[IdxW-1:0];
                     rtrack_in = cur.sound;
                  end
                  if (!nv_ff || diff < nd_ff) begin
                     nv_in = 1'b1; nd_in = diff; nh_in = cur.hour; nm_in = cur.minute;
                  end
               end
            end else begin
               status_in = ST_DONE;
               case (kind_ff)
                  KIND_ADD: begin
                     if (dup_ff) status_in = ST_DUP;
                     else if (count_ff >= CntW'(MaxAlarms)) status_in = ST_FULL;
                     else begin
                        cmd.load = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_REMOVE: begin
                     if (CntW'(idx_ff) >= count_ff || idx_ff > 4'(MaxAlarms - 1))
                        status_in = ST_RANGE;
                     else begin
                        cmd.shift = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  KIND_SET_EN: cmd.write_en = 1'b1;
                  KIND_DIS_ALL: begin
                     cmd.write_en = 1'b1; ring_in = 1'b0; rslot_in = '0; rtrack_in = '0;
                  end
                  KIND_ACK: begin
                     ring_in = 1'b0; rslot_in = '0; rtrack_in = '0;
                  end
                  KIND_CLEAR: begin
                     count_in = '0; ring_in = 1'b0; rslot_in = '0; rtrack_in = '0;
                  end
                  default: ;
               endcase
               pos_in = '0;
            end
         end
         S_RESP: begin
            // Enable summary pass runs while the response waits; it is
            // complete once pos reaches the count, before delivery.
            if (pos_ff < count_ff) begin
               pos_in = pos_ff + 1'b1;
               if (cur.enabled) any_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; ring_ff <= 1'b0;
         rslot_ff <= '0; rtrack_ff <= '0; pos_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ring_ff <= ring_in;
         rslot_ff <= rslot_in; rtrack_ff <= rtrack_in; pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      dup_ff <= dup_in; trig_ff <= trig_in; nv_ff <= nv_in; nh_ff <= nh_in;
      nm_ff <= nm_in; nd_ff <= nd_in; any_ff <= any_in; status_ff <= status_in;
      if (accept) begin
         kind_ff <= kind_type'(req_kind);
         th_ff <= req_time_hour; tm_ff <= req_time_minute; ts_ff <= req_time_second;
         ah_ff <= req_alarm_hour; am_ff <= req_alarm_minute; as_ff <= req_alarm_sound;
         en_ff <= req_enable_flag; idx_ff <= req_entry_index;
         now_ff <= 11'(req_time_hour) * 11'(MinutesHour) + 11'(req_time_minute);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   // Response waits until the enable summary pass has covered every slot.
   assign rsp_valid = (state_ff == S_RESP) && !(pos_ff < count_ff);
   assign rsp_status = status_ff;
   assign rsp_ringing = ring_ff;
   assign rsp_ring_index = ring_ff ? 4'(rslot_ff) : 4'd0;
   assign rsp_ring_sound = ring_ff ? rtrack_ff : 6'd0;
   assign rsp_triggered = trig_ff;
   assign rsp_next_valid = nv_ff;
   assign rsp_next_hour = nh_ff;
   assign rsp_next_minute = nm_ff;
   assign rsp_minutes_until = nd_ff;
   assign rsp_alarm_count = 5'(count_ff);
   assign rsp_any_enabled = any_ff;
endmodule
`default_nettype wire

>>> rtl/msat_cell.sv
// One slot cell of the alarm table: holds a slot, shifts down on remove.
// Depends on msat_pkg.
`default_nettype none
module msat_cell (
   input  wire logic                      clock,
   input  wire logic [msat_pkg::IdxW-1:0] my_index,
   input  wire msat_pkg::cell_cmd_type    cmd,
   input  wire msat_pkg::slot_type        new_slot,
   input  wire msat_pkg::slot_type        up_slot,
   output msat_pkg::slot_type             slot
);
   import msat_pkg::*;
   slot_type slot_ff, slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (cmd.load && cmd.load_index == my_index) begin
         slot_in = new_slot;
      end else if (cmd.shift && my_index >= cmd.rm_index) begin
         slot_in = up_slot;
      end
      if (cmd.write_en) begin
         slot_in.enabled = cmd.en_value;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;
endmodule
`default_nettype wire
